### rtl/sbtda_pkg.sv
`default_nettype none

package sbtda_pkg;

  // Output character width; '-' and the digits fit in six bits.
  localparam int unsigned CHAR_W = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(8'd48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(8'd45);

  localparam int unsigned DIGIT_W = 4;

  // Kick from the converter to the emitter.
  typedef struct packed {
    logic go;
    logic negative;
  } sbtda_start_t;

  // Emitter status back to the top level.
  typedef struct packed {
    logic busy;
    logic finish;
  } sbtda_emit_stat_t;

endpackage : sbtda_pkg

`default_nettype wire

### rtl/sbtda_dabble.sv
`default_nettype none

// Bit-serial binary to BCD: one magnitude bit shifted in per cycle,
// every BCD digit adjusted by +3 when 5 or above before the shift.
module sbtda_dabble #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned DIGITS     = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [VALUE_BITS-1:0]                mag,
  output logic                                      busy,
  output logic                                      done,
  output logic [DIGITS*sbtda_pkg::DIGIT_W-1:0]      bcd
);
  import sbtda_pkg::*;

  localparam int unsigned BCD_W = DIGITS * DIGIT_W;
  localparam int unsigned CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] bin_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      adj;
  logic [BCD_W-1:0]      bcd_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  // add-3 on every digit, digits independent of each other
  always_comb begin
    for (int d = 0; d < int'(DIGITS); d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        bin_r  <= mag;
        bcd_r  <= '0;
        cnt_r  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy_r) begin
        bcd_r  <= bcd_nxt;
        bin_r  <= {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_r  <= cnt_r - CNT_W'(1);
        done_r <= (cnt_r == '0);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign bcd  = bcd_r;

endmodule : sbtda_dabble

`default_nettype wire

### rtl/sbtda_emit.sv
`default_nettype none

// Drops leading zero digits, then sends the sign and the digits,
// top digit first, through the output register.
module sbtda_emit #(
  parameter int unsigned DIGITS = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sbtda_pkg::sbtda_start_t             start,
  input  wire logic [DIGITS*sbtda_pkg::DIGIT_W-1:0] bcd,
  output sbtda_pkg::sbtda_emit_stat_t              stat,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [sbtda_pkg::CHAR_W-1:0]             out_character,
  output logic                                     out_last
);
  import sbtda_pkg::*;

  localparam int unsigned BCD_W = DIGITS * DIGIT_W;
  localparam int unsigned REM_W = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic [BCD_W-1:0]   dig_r;
  logic [REM_W-1:0]   rem_r;
  logic               sign_pend_r;
  logic               finish_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_character_r;
  logic               out_last_r;
  logic [DIGIT_W-1:0] top_dig;
  logic               slot_free;
  logic               emit_load;

  assign top_dig   = dig_r[BCD_W-1 -: DIGIT_W];
  assign slot_free = !out_valid_r || !out_stall;
  // a character enters the output register this cycle
  assign emit_load = (state_r == ST_EMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      finish_r    <= 1'b0;
    end else begin
      finish_r <= emit_load && !sign_pend_r && (rem_r == REM_W'(1));
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start.go) begin
            dig_r       <= bcd;
            rem_r       <= REM_W'(DIGITS);
            sign_pend_r <= start.negative;
            state_r     <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // keep at least one digit so zero prints as '0'
          if (top_dig == '0 && rem_r > REM_W'(1)) begin
            dig_r <= {dig_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            rem_r <= rem_r - REM_W'(1);
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (sign_pend_r) begin
              out_character_r <= ASCII_MINUS;
              out_last_r      <= 1'b0;
              sign_pend_r     <= 1'b0;
            end else begin
              out_character_r <= ASCII_ZERO + CHAR_W'(top_dig);
              out_last_r      <= (rem_r == REM_W'(1));
              dig_r           <= {dig_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
              rem_r           <= rem_r - REM_W'(1);
              if (rem_r == REM_W'(1)) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.finish    = finish_r;
  assign out_valid      = out_valid_r;
  assign out_character  = out_character_r;
  assign out_last       = out_last_r;

endmodule : sbtda_emit

`default_nettype wire

### rtl/signed_binary_to_decimal_ascii.sv
`default_nettype none

// Signed integer to decimal ASCII. Each in_value beat (two's complement,
// VALUE_BITS wide) comes out as its decimal text, one character per out
// beat, most significant first: '-' for a negative value, then the digits
// with no leading zeros ("0" for zero), out_last on the final character.
// The most negative value prints in full (-2147483648 at 32 bits). One
// number is worked on at a time: in_stall is high from the accepted beat
// until the last character of that number has entered the output register.
// Steps per number: accept, the bit-serial BCD converter (one magnitude
// bit per cycle), hand over, walk past leading zeros, then send each
// character. Stalls on out_stall stretch the sending phase beat for beat;
// nothing is dropped.
module signed_binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [VALUE_BITS-1:0]   in_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [sbtda_pkg::CHAR_W-1:0]        out_character,
  output logic                                out_last
);
  import sbtda_pkg::*;

  // decimal digits in 2^(VALUE_BITS-1), the largest magnitude
  localparam int unsigned DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_W  = DIGITS * DIGIT_W;

  logic                  busy_r;
  logic                  neg_r;
  logic                  in_beat;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  dab_busy;
  logic                  dab_done;
  logic [BCD_W-1:0]      bcd;
  sbtda_start_t          emit_start;
  sbtda_emit_stat_t      emit_stat;

  assign in_stall = busy_r;
  assign in_beat  = in_valid && !in_stall;
  assign in_neg   = in_value[VALUE_BITS-1];

  // Two's complement negate; the most negative value maps onto itself,
  // which read unsigned is exactly its magnitude.
  assign mag = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      if (in_beat) begin
        busy_r <= 1'b1;
      end else if (emit_stat.finish) begin
        busy_r <= 1'b0;
      end
    end
  end

  // sign held for the emitter
  always_ff @(posedge clk) begin
    if (in_beat) begin
      neg_r <= in_neg;
    end
  end

  sbtda_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_beat),
    .mag   (mag),
    .busy  (dab_busy),
    .done  (dab_done),
    .bcd   (bcd)
  );

  assign emit_start.go       = dab_done;
  assign emit_start.negative = neg_r;

  sbtda_emit #(
    .DIGITS (DIGITS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (emit_start),
    .bcd           (bcd),
    .stat          (emit_stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // no new number while one is still being converted or sent
  a_accept_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> in_stall)
    else $error("input accepted while a number was in flight");

  // converter and emitter never run at once
  a_one_unit : assert property (@(posedge clk) disable iff (!rst_n)
    !(dab_busy && emit_stat.busy))
    else $error("converter and emitter active together");

  // the final character is always a digit
  a_last_digit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |->
      (out_character >= ASCII_ZERO && out_character <= ASCII_ZERO + CHAR_W'(9)))
    else $error("last beat is not a digit");

  // a minus sign never ends a number
  a_minus_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == ASCII_MINUS) |-> !out_last)
    else $error("minus sign marked last");

endmodule : signed_binary_to_decimal_ascii

`default_nettype wire

### tb/signed_binary_to_decimal_ascii_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the signed integer to decimal ASCII converter.
// Each number sent in produces a burst of character beats: an optional
// minus sign, then the digits with the top one first. The final beat is
// flagged with out_last. A text predictor, or a directed row's typed text,
// lists each number's expected beats; the output monitor pops them in order.
module signed_binary_to_decimal_ascii_test;
  import sbtda_pkg::*;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned TEXT_BYTES = 11;   // longest text: "-2147483648"
  localparam int unsigned RANDOM_NUMBERS = 390;
  localparam int unsigned DIRECTED_ROWS = 20;

  localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // One output beat as the block should present it.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } char_beat_t;

  // Directed row: a value and, where it is obvious, its text typed in.
  // An all-zero text means the predictor supplies the expectation.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [8*TEXT_BYTES-1:0]      text;
  } text_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [VALUE_BITS-1:0]  in_value;
  logic                          out_valid;
  logic                          out_stall;
  logic [CHAR_W-1:0]             out_character;
  logic                          out_last;

  char_beat_t pending_chars[$];   // characters still owed by the block
  char_beat_t want_beat;

  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned numbers_sent;
  int unsigned negatives_sent;
  int unsigned stall_left;
  bit          bursts_on;          // random idling on both sides when set

  text_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'sd0,           "0"},
    '{32'sd1,           "1"},
    '{-32'sd1,          "-1"},
    '{MOST_POS,         "2147483647"},
    '{MOST_NEG,         "-2147483648"},
    '{-32'sd2147483647, "-2147483647"},
    '{32'sd9,           ""},
    '{32'sd10,          ""},
    '{-32'sd10,         ""},
    '{32'sd99,          ""},
    '{32'sd100,         ""},
    '{-32'sd9,          ""},
    '{32'sd999999999,   ""},
    '{32'sd1000000000,  ""},
    '{-32'sd999999999,  ""},
    '{-32'sd1000000000, ""},
    '{32'sh5555_5555,   ""},
    '{32'shAAAA_AAAA,   ""},
    '{32'sd1234567890,  ""},
    '{32'sd7,           ""}
  };

  signed_binary_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Hard stop, several times the slowest legal run: 410 numbers, each with
  // every beat stalled as long as the bench allows and the longest input gap.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    if (mismatches < 10) begin
      $display("[%0t] mismatch: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    end
    mismatches++;
  endfunction

  // Decimal text predictor: sign from the top bit, magnitude taken modulo
  // 2^VALUE_BITS so the most negative value keeps its full magnitude.
  function automatic void predict_text(logic signed [VALUE_BITS-1:0] v);
    logic                  negative;
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_W-1:0]    digits [TEXT_BYTES];
    int                    ndig;
    char_beat_t            beat;
    negative = v[VALUE_BITS-1];
    mag = negative ? (~v + 1'b1) : v;
    ndig = 0;
    do begin
      digits[ndig] = DIGIT_W'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0);
    if (negative) begin
      beat.character = ASCII_MINUS;
      beat.last = 1'b0;
      pending_chars.push_back(beat);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      beat.character = ASCII_ZERO + CHAR_W'(digits[i]);
      beat.last = (i == 0);
      pending_chars.push_back(beat);
    end
  endfunction

  // Typed-in text straight to beats; leading zero bytes are padding.
  function automatic void queue_text(logic [8*TEXT_BYTES-1:0] text);
    char_beat_t beat;
    int         last_idx;
    last_idx = -1;
    for (int i = 0; i < TEXT_BYTES; i++) begin
      if (text[8*i +: 8] != 8'd0 && last_idx < 0) last_idx = i;
    end
    for (int i = TEXT_BYTES - 1; i >= 0; i--) begin
      if (text[8*i +: 8] != 8'd0) begin
        beat.character = text[8*i +: CHAR_W];
        beat.last = (i == last_idx);
        pending_chars.push_back(beat);
      end
    end
  endfunction

  // Present one number and hold it until the beat is taken. Valid stays high
  // (bar random gaps when bursts_on) so a following number goes back to back.
  task automatic send_number(logic signed [VALUE_BITS-1:0] v, logic [8*TEXT_BYTES-1:0] text);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    if (text != '0) queue_text(text);
    else predict_text(v);
    numbers_sent++;
    if (v[VALUE_BITS-1]) negatives_sent++;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Random value with a spread of text lengths; four in ten pick a random bit
  // width so short numbers are as common as ten-digit ones.
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] pow;
    int unsigned           k;
    case ($urandom_range(0, 9))
      0: begin
        v = $urandom_range(0, 20);
        if ($urandom_range(0, 1)) v = -v;
      end
      1: begin
        pow = 1;
        k = $urandom_range(0, 9);
        repeat (k) pow = pow * 10;
        v = pow + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
        if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
      end
      2, 3, 4, 5: begin
        k = $urandom_range(1, VALUE_BITS - 1);
        v = $urandom & ((VALUE_BITS'(1) << k) - 1'b1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Receiver back-pressure: stall bursts of random length when enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 18);
    end
  end

  // Output checker: every taken beat must match the oldest owed character.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        note_mismatch("unexpected beat, character", 0, out_character);
      end else begin
        want_beat = pending_chars.pop_front();
        beats_checked++;
        if (out_character !== want_beat.character) begin
          note_mismatch("character", want_beat.character, out_character);
        end
        if (out_last !== want_beat.last) begin
          note_mismatch("last flag", want_beat.last, out_last);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    out_stall = 1'b0;
    mismatches = 0;
    beats_checked = 0;
    numbers_sent = 0;
    negatives_sent = 0;
    stall_left = 0;
    bursts_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, sign and digit-count boundaries, alternating bits.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_number(directed_rows[i].value, directed_rows[i].text);
    end

    // Let the block drain completely before the random part.
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);

    // Random part: idling on, then a calm stretch, then on again, and a
    // final stretch with no idling at all.
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      bursts_on = !((n >= 120 && n < 180) || n >= 330);
      send_number(pick_value(), '0);
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    // Room for any stray beats after the last expected one.
    repeat (60) @(posedge clk);
    if (pending_chars.size() != 0) note_mismatch("characters left over", 0,
                                                 pending_chars.size());

    $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
             numbers_sent, negatives_sent, beats_checked);
    $display("with random gaps and output stalls; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
